// ===== rtl/core/tlfs_pkg.sv =====
// Shared types, codes and reset constants of the thermal level fan supervisor.
`default_nettype none

package tlfs_pkg;

   typedef enum logic [2:0] {
      LEVEL_COLD     = 3'd0,
      LEVEL_LOW      = 3'd1,
      LEVEL_MEDIUM   = 3'd2,
      LEVEL_HIGH     = 3'd3,
      LEVEL_CRITICAL = 3'd4
   } level_type;

   typedef enum logic [1:0] {
      CAUSE_NONE     = 2'd0,
      CAUSE_OVERTEMP = 2'd1,
      CAUSE_SENSOR   = 2'd2
   } cause_type;

   localparam int NUM_THRESHOLDS = 4;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int MARGIN_WIDTH = 8;
   localparam int TIMEOUT_WIDTH = 16;
   localparam int DUTY_WIDTH = 7;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_LOW_THRESHOLD      = 3'd0;
   localparam csr_index_type CSR_MEDIUM_THRESHOLD   = 3'd1;
   localparam csr_index_type CSR_HIGH_THRESHOLD     = 3'd2;
   localparam csr_index_type CSR_CRITICAL_THRESHOLD = 3'd3;
   localparam csr_index_type CSR_HYSTERESIS_MARGIN  = 3'd4;
   localparam csr_index_type CSR_REVOKE_TIMEOUT     = 3'd5;

   localparam int LOW_THRESHOLD_RESET      = 480;
   localparam int MEDIUM_THRESHOLD_RESET   = 640;
   localparam int HIGH_THRESHOLD_RESET     = 800;
   localparam int CRITICAL_THRESHOLD_RESET = 960;
   localparam logic [MARGIN_WIDTH-1:0] MARGIN_RESET = 8'd32;
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 16'd20;

   localparam logic [DUTY_WIDTH-1:0] DUTY_IDLE = 7'd40;
   localparam logic [DUTY_WIDTH-1:0] DUTY_WARM = 7'd60;
   localparam logic [DUTY_WIDTH-1:0] DUTY_HOT  = 7'd80;
   localparam logic [DUTY_WIDTH-1:0] DUTY_FULL = 7'd100;

   function automatic logic [DUTY_WIDTH-1:0] level_duty(input level_type level);
      logic [DUTY_WIDTH-1:0] duty;
      case (level)
         LEVEL_COLD:   duty = DUTY_IDLE;
         LEVEL_LOW:    duty = DUTY_WARM;
         LEVEL_MEDIUM: duty = DUTY_HOT;
         default:      duty = DUTY_FULL;
      endcase
      return duty;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tlfs_classify.sv =====
// Threshold classifier with downward hysteresis.
`default_nettype none

module tlfs_classify #(
   parameter int TEMP_WIDTH = 16
) (
   input  wire logic signed [TEMP_WIDTH-1:0]              temperature,
   input  wire tlfs_pkg::level_type                       previous_level,
   input  wire logic signed [TEMP_WIDTH-1:0]              thresholds [tlfs_pkg::NUM_THRESHOLDS],
   input  wire logic        [tlfs_pkg::MARGIN_WIDTH-1:0]  margin,
   output tlfs_pkg::level_type                            level
);
   import tlfs_pkg::*;

   // two guard bits: threshold minus margin never wraps
   localparam int EXT_WIDTH = TEMP_WIDTH + 2;

   logic signed [EXT_WIDTH-1:0] temp_ext;
   logic signed [EXT_WIDTH-1:0] margin_ext;
   logic signed [EXT_WIDTH-1:0] effective [NUM_THRESHOLDS];
   logic        [NUM_THRESHOLDS-1:0] reached;

   assign temp_ext   = EXT_WIDTH'(temperature);
   assign margin_ext = $signed({{(EXT_WIDTH-MARGIN_WIDTH){1'b0}}, margin});

   always_comb begin
      for (int i = 0; i < NUM_THRESHOLDS; i++) begin
         if (previous_level > 3'(i)) begin
            effective[i] = EXT_WIDTH'(thresholds[i]) - margin_ext;
         end else begin
            effective[i] = EXT_WIDTH'(thresholds[i]);
         end
         reached[i] = (temp_ext >= effective[i]);
      end
   end

   // last threshold reached in fixed order wins, even if unordered
   always_comb begin
      level = LEVEL_COLD;
      for (int i = 0; i < NUM_THRESHOLDS; i++) begin
         if (reached[i]) begin
            level = level_type'(3'(i + 1));
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/thermal_level_fan_supervisor_top.sv =====
// Thermal level fan supervisor: input register, classifier and result register.
// Path: an accepted word waits in the input register and moves into the result
// register when that register is empty or its word is not stalled.
// Throughput: one word per cycle while rsp_stall is low; the input register can
// take one more word while a result waits, but req_stall rises once it is full.
// Reset: synchronous, active high; clears valids, level (cold) and tick count,
// and reloads the thresholds, margin and timeout with their defaults.
`default_nettype none

module thermal_level_fan_supervisor_top #(
   parameter int TEMP_WIDTH  = 16,
   parameter int COUNT_WIDTH = 16,
   localparam int CSR_WIDTH  = (TEMP_WIDTH > 16) ? TEMP_WIDTH : 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [TEMP_WIDTH-1:0]           req_temperature,
   input  wire logic                                   req_sensor_fault,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output tlfs_pkg::level_type                         rsp_thermal_level,
   output tlfs_pkg::cause_type                         rsp_critical_cause,
   output logic [tlfs_pkg::DUTY_WIDTH-1:0]             rsp_fan_duty_percent,
   output logic [COUNT_WIDTH-1:0]                      rsp_overtemp_ticks,
   output logic                                        rsp_keep_alive_revoked,
   input  wire logic                                   csr_we,
   input  wire tlfs_pkg::csr_index_type                csr_index,
   input  wire logic [CSR_WIDTH-1:0]                   csr_wdata
);
   import tlfs_pkg::*;

   localparam int CMP_WIDTH = (COUNT_WIDTH > TIMEOUT_WIDTH) ? COUNT_WIDTH : TIMEOUT_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // configuration
   logic signed [TEMP_WIDTH-1:0]    threshold_ff [NUM_THRESHOLDS];
   logic        [MARGIN_WIDTH-1:0]  margin_ff;
   logic        [TIMEOUT_WIDTH-1:0] timeout_ff;

   // input register
   logic                         s1_valid_ff;
   logic signed [TEMP_WIDTH-1:0] s1_temp_ff;
   logic                         s1_fault_ff;

   // state
   level_type                    prev_level_ff;
   logic [COUNT_WIDTH-1:0]       count_ff;

   // result register
   logic                         out_valid_ff;
   level_type                    out_level_ff;
   cause_type                    out_cause_ff;
   logic [DUTY_WIDTH-1:0]        out_duty_ff;
   logic [COUNT_WIDTH-1:0]       out_count_ff;
   logic                         out_revoked_ff;

   logic                         advance;
   logic                         req_accept;
   level_type                    class_level;
   level_type                    level_in;
   cause_type                    cause_in;
   logic [DUTY_WIDTH-1:0]        duty_in;
   logic [COUNT_WIDTH-1:0]       count_in;
   logic                         revoked_in;

   assign advance    = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff[0] <= TEMP_WIDTH'(LOW_THRESHOLD_RESET);
         threshold_ff[1] <= TEMP_WIDTH'(MEDIUM_THRESHOLD_RESET);
         threshold_ff[2] <= TEMP_WIDTH'(HIGH_THRESHOLD_RESET);
         threshold_ff[3] <= TEMP_WIDTH'(CRITICAL_THRESHOLD_RESET);
         margin_ff       <= MARGIN_RESET;
         timeout_ff      <= TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOW_THRESHOLD:      threshold_ff[0] <= csr_wdata[TEMP_WIDTH-1:0];
            CSR_MEDIUM_THRESHOLD:   threshold_ff[1] <= csr_wdata[TEMP_WIDTH-1:0];
            CSR_HIGH_THRESHOLD:     threshold_ff[2] <= csr_wdata[TEMP_WIDTH-1:0];
            CSR_CRITICAL_THRESHOLD: threshold_ff[3] <= csr_wdata[TEMP_WIDTH-1:0];
            CSR_HYSTERESIS_MARGIN:  margin_ff       <= csr_wdata[MARGIN_WIDTH-1:0];
            CSR_REVOKE_TIMEOUT:     timeout_ff      <= csr_wdata[TIMEOUT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   tlfs_classify #(
      .TEMP_WIDTH (TEMP_WIDTH)
   ) u_classify (
      .temperature    (s1_temp_ff),
      .previous_level (prev_level_ff),
      .thresholds     (threshold_ff),
      .margin         (margin_ff),
      .level          (class_level)
   );

   always_comb begin
      if (s1_fault_ff) begin
         level_in = LEVEL_CRITICAL;
         cause_in = CAUSE_SENSOR;
      end else begin
         level_in = class_level;
         cause_in = (class_level == LEVEL_CRITICAL) ? CAUSE_OVERTEMP : CAUSE_NONE;
      end
      duty_in = level_duty(level_in);
      if (cause_in == CAUSE_OVERTEMP) begin
         count_in   = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
         revoked_in = (CMP_WIDTH'(count_in) >= CMP_WIDTH'(timeout_ff));
      end else begin
         count_in   = '0;
         revoked_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         prev_level_ff <= LEVEL_COLD;
         count_ff      <= '0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff  <= 1'b1;
            prev_level_ff <= level_in;
            count_ff      <= count_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_temp_ff  <= req_temperature;
         s1_fault_ff <= req_sensor_fault;
      end
      if (advance) begin
         out_level_ff   <= level_in;
         out_cause_ff   <= cause_in;
         out_duty_ff    <= duty_in;
         out_count_ff   <= count_in;
         out_revoked_ff <= revoked_in;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_thermal_level      = out_level_ff;
   assign rsp_critical_cause     = out_cause_ff;
   assign rsp_fan_duty_percent   = out_duty_ff;
   assign rsp_overtemp_ticks     = out_count_ff;
   assign rsp_keep_alive_revoked = out_revoked_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tlfs_checker.sv =====
// Port-level checks of the thermal level fan supervisor, bound to the top level.
`default_nettype none

module tlfs_checker #(
   parameter int COUNT_WIDTH = 16
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire tlfs_pkg::level_type               rsp_thermal_level,
   input wire tlfs_pkg::cause_type               rsp_critical_cause,
   input wire logic [tlfs_pkg::DUTY_WIDTH-1:0]   rsp_fan_duty_percent,
   input wire logic [COUNT_WIDTH-1:0]            rsp_overtemp_ticks,
   input wire logic                              rsp_keep_alive_revoked
);
   import tlfs_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_thermal_level)
         && $stable(rsp_critical_cause) && $stable(rsp_fan_duty_percent)
         && $stable(rsp_overtemp_ticks) && $stable(rsp_keep_alive_revoked))
      else $error("stalled result word changed");

   // input only backs up behind a stalled result word
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while the result side was free");

   // below critical: no cause, counter cleared, keep-alive held
   a_noncrit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_thermal_level != LEVEL_CRITICAL |->
         rsp_critical_cause == CAUSE_NONE && rsp_overtemp_ticks == '0
         && !rsp_keep_alive_revoked)
      else $error("non-critical word carries critical status");

   // critical: full duty, a cause, and a sensor fault clears the count
   a_crit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_thermal_level == LEVEL_CRITICAL |->
         rsp_fan_duty_percent == DUTY_FULL && rsp_critical_cause != CAUSE_NONE
         && (rsp_critical_cause != CAUSE_SENSOR || rsp_overtemp_ticks == '0))
      else $error("critical word without full duty or cause");

   a_revoke: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_keep_alive_revoked |->
         rsp_critical_cause == CAUSE_OVERTEMP && rsp_overtemp_ticks != '0)
      else $error("keep-alive revoked without overtemperature count");

endmodule

bind thermal_level_fan_supervisor_top tlfs_checker #(
   .COUNT_WIDTH (COUNT_WIDTH)
) u_tlfs_checker (.*);

`default_nettype wire
